// ----- hw/rtl/dfpv_pkg.sv -----
// package: formats, widths and pipeline tag for the demons force block
`default_nettype none
package dfpv_pkg;
	localparam int VALUE_WIDTH   = 16;
	localparam int FRACTION_BITS = 12;
	localparam int ALPHA_FRAC    = 16;
	localparam int ALPHA_W       = 24;
	localparam int MODE_W        = 2;

	localparam int DIFF_W  = VALUE_WIDTH + 1;          // signed difference / gradient sum
	localparam int MAG_W   = VALUE_WIDTH;              // |d|
	localparam int GMAG_W  = VALUE_WIDTH + 1;          // |g|
	localparam int SQ_W    = 2 * VALUE_WIDTH - 1;      // one squared component
	localparam int SSQ_W   = 2 * VALUE_WIDTH;          // sum of two squares
	localparam int PROD_W  = 2 * VALUE_WIDTH;          // |d|*|g|
	localparam int ATERM_W = ALPHA_W + 2 * MAG_W;      // alpha * d^2
	localparam int DEN_W   = ATERM_W + 1;              // denominator
	localparam int NUM_W   = PROD_W + FRACTION_BITS + ALPHA_FRAC + 1;
	localparam int QW      = 2 * VALUE_WIDTH - 1;      // quotient magnitude bits
	localparam int LANES   = 4;
	localparam int DIV_LAT = QW + 1;

	localparam logic [MODE_W-1:0] MODE_PASSIVE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ACTIVE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_INVCON  = 2'd2;

	localparam logic [0:0] REG_FORCE_MODE = 1'b0;
	localparam logic [0:0] REG_ALPHA_SQ   = 1'b1;

	localparam logic [MODE_W-1:0]  MODE_RESET  = MODE_INVCON;
	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 24'd32113;

	typedef struct packed {
		logic             valid;
		logic [LANES-1:0] neg;
		logic             degen;
	} tag_t;
endpackage
`default_nettype wire

// ----- hw/rtl/demons_force_per_vertex.sv -----
// top level: demons displacement force per mesh vertex, fully pipelined
//
// channel   direction  handshake            payload
// in        inbound    in_valid / in_stall   six Q3.12 values and gradients
// out       outbound   out_valid / out_stall force_theta, force_phi, degenerate, saturated
// cfg       inbound    apb psel/penable      force_mode @0x0, alpha_squared @0x4
//
// one vertex transaction enters per cycle unless the output stalls; the path runs through
// the four front stages, the 32-stage restoring divider lanes (a load stage, then one
// quotient bit per stage) and the output register
// reset clears all valid bits and loads force_mode = 2, alpha_squared = 32113
// a stall at the output with a result waiting freezes every stage and raises in_stall
`default_nettype none
module demons_force_per_vertex import dfpv_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input transaction
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [VALUE_WIDTH-1:0] source_value,
	input  wire logic signed [VALUE_WIDTH-1:0] target_value,
	input  wire logic signed [VALUE_WIDTH-1:0] target_grad_theta,
	input  wire logic signed [VALUE_WIDTH-1:0] target_grad_phi,
	input  wire logic signed [VALUE_WIDTH-1:0] source_grad_theta,
	input  wire logic signed [VALUE_WIDTH-1:0] source_grad_phi,
	// result transaction
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [VALUE_WIDTH-1:0]      force_theta,
	output logic signed [VALUE_WIDTH-1:0]      force_phi,
	output logic                               degenerate,
	output logic                               saturated,
	// configuration
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [2:0]                    paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	logic [MODE_W-1:0]  force_mode_q;
	logic [ALPHA_W-1:0] alpha_sq_q;
	logic               en;

	// registers; address bit 2 selects the register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			force_mode_q <= MODE_RESET;
			alpha_sq_q   <= ALPHA_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_FORCE_MODE: force_mode_q <= pwdata[MODE_W-1:0];
				REG_ALPHA_SQ:   alpha_sq_q   <= pwdata[ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_FORCE_MODE: prdata = 32'(force_mode_q);
			REG_ALPHA_SQ:   prdata = 32'(alpha_sq_q);
			default:        prdata = '0;
		endcase
	end

	// whole pipeline advances unless a finished result is held back
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	logic [LANES-1:0][NUM_W-1:0] num;
	logic [LANES-1:0][DEN_W-1:0] den;
	logic [LANES-1:0][QW-1:0]    quo;
	tag_t                        tag_f;

	dfpv_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.mode     (force_mode_q),
		.alpha    (alpha_sq_q),
		.sv       (source_value),
		.tv       (target_value),
		.tt       (target_grad_theta),
		.tp       (target_grad_phi),
		.st       (source_grad_theta),
		.sp       (source_grad_phi),
		.num      (num),
		.den      (den),
		.tag      (tag_f)
	);

	// lanes 0/1: theta/phi over the main denominator; lanes 2/3: active terms
	for (genvar i = 0; i < LANES; i++) begin : g_lane
		dfpv_div_lane u_div (
			.clk (clk),
			.en  (en),
			.num (num[i]),
			.den (den[i]),
			.quo (quo[i])
		);
	end

	// tag rides alongside the divider stages
	tag_t tag_q [DIV_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_LAT; k++) tag_q[k] <= '0;
		end else if (en) begin
			tag_q[0] <= tag_f;
			for (int k = 1; k < DIV_LAT; k++) tag_q[k] <= tag_q[k-1];
		end
	end

	dfpv_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.mode        (force_mode_q),
		.tag         (tag_q[DIV_LAT-1]),
		.quo         (quo),
		.out_valid   (out_valid),
		.force_theta (force_theta),
		.force_phi   (force_phi),
		.degenerate  (degenerate),
		.saturated   (saturated)
	);
endmodule
`default_nettype wire

// ----- hw/rtl/dfpv_front.sv -----
// front stages: difference, squares, products, denominators and numerators
`default_nettype none
module dfpv_front import dfpv_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire logic [MODE_W-1:0]             mode,
	input  wire logic [ALPHA_W-1:0]            alpha,
	input  wire logic signed [VALUE_WIDTH-1:0] sv,
	input  wire logic signed [VALUE_WIDTH-1:0] tv,
	input  wire logic signed [VALUE_WIDTH-1:0] tt,
	input  wire logic signed [VALUE_WIDTH-1:0] tp,
	input  wire logic signed [VALUE_WIDTH-1:0] st,
	input  wire logic signed [VALUE_WIDTH-1:0] sp,
	output logic [LANES-1:0][NUM_W-1:0]        num,
	output logic [LANES-1:0][DEN_W-1:0]        den,
	output tag_t                               tag
);
	logic inv;
	assign inv = mode[1];

	// stage 1
	logic signed [DIFF_W-1:0] d_c;
	logic signed [DIFF_W-1:0] g_c [LANES];
	logic [GMAG_W-1:0]        ag_c [LANES];
	logic [SQ_W-1:0]          sq_c [LANES];
	logic signed [VALUE_WIDTH-1:0] gin [LANES];
	logic [MAG_W-1:0]         ad_s1_c;

	logic                     v_s1;
	logic [MAG_W-1:0]         ad_s1;
	logic                     dneg_s1;
	logic [GMAG_W-1:0]        ag_s1 [LANES];
	logic [LANES-1:0]         gneg_s1;
	logic [SQ_W-1:0]          sq_s1 [LANES];

	assign gin[0] = tt;
	assign gin[1] = tp;
	assign gin[2] = st;
	assign gin[3] = sp;

	always_comb begin
		logic [DIFF_W-1:0] ad_w;
		d_c = DIFF_W'(sv) - DIFF_W'(tv);
		g_c[0] = inv ? DIFF_W'(tt) + DIFF_W'(st) : DIFF_W'(tt);
		g_c[1] = inv ? DIFF_W'(tp) + DIFF_W'(sp) : DIFF_W'(tp);
		g_c[2] = DIFF_W'(st);
		g_c[3] = DIFF_W'(sp);
		for (int i = 0; i < LANES; i++) begin
			ag_c[i] = g_c[i][DIFF_W-1] ? GMAG_W'(-g_c[i]) : GMAG_W'(g_c[i]);
			sq_c[i] = SQ_W'(gin[i] * gin[i]);
		end
		ad_w = d_c[DIFF_W-1] ? DIFF_W'(-d_c) : DIFF_W'(d_c);
		ad_s1_c = ad_w[MAG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ad_s1   <= ad_s1_c;
			dneg_s1 <= d_c[DIFF_W-1];
			for (int i = 0; i < LANES; i++) begin
				ag_s1[i]   <= ag_c[i];
				gneg_s1[i] <= g_c[i][DIFF_W-1];
				sq_s1[i]   <= sq_c[i];
			end
		end
	end

	// stage 2
	logic                 v_s2;
	logic [SSQ_W-1:0]     ad2_s2;
	logic [SSQ_W-1:0]     gt2_s2, gs2_s2;
	logic [PROD_W-1:0]    prod_s2 [LANES];
	logic [LANES-1:0]     neg_s2;
	logic [PROD_W:0]      prod_c [LANES];

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			prod_c[i] = (PROD_W+1)'(ad_s1) * (PROD_W+1)'(ag_s1[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ad2_s2 <= SSQ_W'(ad_s1) * SSQ_W'(ad_s1);
			gt2_s2 <= SSQ_W'(sq_s1[0]) + SSQ_W'(sq_s1[1]);
			gs2_s2 <= SSQ_W'(sq_s1[2]) + SSQ_W'(sq_s1[3]);
			for (int i = 0; i < LANES; i++) begin
				prod_s2[i] <= prod_c[i][PROD_W-1:0];
				neg_s2[i]  <= dneg_s1 ^ gneg_s1[i];
			end
		end
	end

	// stage 3
	logic                 v_s3;
	logic [ATERM_W-1:0]   aterm_s3;
	logic [SSQ_W-1:0]     gt2_s3, gs2_s3;
	logic [PROD_W-1:0]    prod_s3 [LANES];
	logic [LANES-1:0]     neg_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			aterm_s3 <= ATERM_W'(alpha) * ATERM_W'(ad2_s2);
			gt2_s3   <= gt2_s2;
			gs2_s3   <= gs2_s2;
			prod_s3  <= prod_s2;
			neg_s3   <= neg_s2;
		end
	end

	// stage 4
	logic [DEN_W-1:0] den_a, den_b;
	logic [SSQ_W:0]   gsum;
	logic [DEN_W-1:0] den_l [LANES];
	logic             zero_a, zero_b;
	tag_t             tag_s4;
	logic [LANES-1:0][NUM_W-1:0] num_s4;
	logic [LANES-1:0][DEN_W-1:0] den_s4;

	always_comb begin
		gsum  = inv ? (SSQ_W+1)'(gt2_s3) + (SSQ_W+1)'(gs2_s3) : (SSQ_W+1)'(gt2_s3);
		den_a = (DEN_W'(gsum) << ALPHA_FRAC) + DEN_W'(aterm_s3);
		den_b = (DEN_W'(gs2_s3) << ALPHA_FRAC) + DEN_W'(aterm_s3);
		zero_a = (den_a == '0);
		zero_b = (den_b == '0);
		den_l[0] = den_a;
		den_l[1] = den_a;
		den_l[2] = den_b;
		den_l[3] = den_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s4 <= '0;
		end else if (en) begin
			tag_s4.valid <= v_s3;
			tag_s4.neg   <= neg_s3;
			tag_s4.degen <= zero_a || (mode == MODE_ACTIVE && zero_b);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < LANES; i++) begin
				den_s4[i] <= den_l[i];
				num_s4[i] <= (NUM_W'(prod_s3[i]) << (FRACTION_BITS + ALPHA_FRAC))
					+ NUM_W'(den_l[i] >> 1);
			end
		end
	end

	assign num = num_s4;
	assign den = den_s4;
	assign tag = tag_s4;
endmodule
`default_nettype wire

// ----- hw/rtl/dfpv_div_lane.sv -----
// pipelined restoring divider lane: a load stage, then one quotient bit per stage
`default_nettype none
module dfpv_div_lane import dfpv_pkg::*; (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic      [QW-1:0]    quo
);
	logic [DEN_W-1:0] rem_s [QW+1];
	logic [QW-1:0]    low_s [QW+1];
	logic [DEN_W-1:0] den_s [QW+1];
	logic [QW-1:0]    quo_s [QW+1];

	// quotient is known to fit in QW bits, so the top part is already below den
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= DEN_W'(num[NUM_W-1:QW]);
			low_s[0] <= num[QW-1:0];
			den_s[0] <= den;
			quo_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		always_comb begin
			trial = {rem_s[k], low_s[k][QW-1]};
			diff  = trial - {1'b0, den_s[k]};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= diff[DEN_W] ? trial[DEN_W-1:0] : diff[DEN_W-1:0];
				low_s[k+1] <= {low_s[k][QW-2:0], 1'b0};
				den_s[k+1] <= den_s[k];
				quo_s[k+1] <= {quo_s[k][QW-2:0], ~diff[DEN_W]};
			end
		end
	end

	assign quo = quo_s[QW];
endmodule
`default_nettype wire

// ----- hw/rtl/dfpv_back.sv -----
// back stage: signs, mode one sum, saturation and output register
`default_nettype none
module dfpv_back import dfpv_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic [MODE_W-1:0]       mode,
	input  wire tag_t                    tag,
	input  wire logic [LANES-1:0][QW-1:0] quo,
	output logic                         out_valid,
	output logic signed [VALUE_WIDTH-1:0] force_theta,
	output logic signed [VALUE_WIDTH-1:0] force_phi,
	output logic                         degenerate,
	output logic                         saturated
);
	localparam int SUM_W = QW + 3;
	localparam logic signed [SUM_W-1:0] VMAX = SUM_W'((64'sd1 <<< (VALUE_WIDTH - 1)) - 1);
	localparam logic signed [SUM_W-1:0] VMIN = -SUM_W'(64'sd1 <<< (VALUE_WIDTH - 1));

	logic signed [SUM_W-1:0] sv [LANES];
	logic signed [SUM_W-1:0] tot [2];
	logic [VALUE_WIDTH-1:0]  res [2];
	logic [1:0]              clip;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			sv[i] = tag.neg[i] ? -$signed(SUM_W'(quo[i])) : $signed(SUM_W'(quo[i]));
		end
		for (int c = 0; c < 2; c++) begin
			tot[c] = sv[c] + ((mode == MODE_ACTIVE) ? sv[c+2] : '0);
			if (tot[c] > VMAX) begin
				res[c]  = VMAX[VALUE_WIDTH-1:0];
				clip[c] = 1'b1;
			end else if (tot[c] < VMIN) begin
				res[c]  = VMIN[VALUE_WIDTH-1:0];
				clip[c] = 1'b1;
			end else begin
				res[c]  = tot[c][VALUE_WIDTH-1:0];
				clip[c] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= tag.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			force_theta <= tag.degen ? '0 : res[0];
			force_phi   <= tag.degen ? '0 : res[1];
			degenerate  <= tag.degen;
			saturated   <= !tag.degen && (clip != 2'b00);
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/dfpv_checker.sv -----
// port checker for the demons force block and its bind
`default_nettype none
module dfpv_checker import dfpv_pkg::*; (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_stall,
	input wire logic                   out_valid,
	input wire logic                   out_stall,
	input wire logic [VALUE_WIDTH-1:0] force_theta,
	input wire logic [VALUE_WIDTH-1:0] force_phi,
	input wire logic                   degenerate,
	input wire logic                   saturated
);
	localparam logic [VALUE_WIDTH-1:0] PMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic [VALUE_WIDTH-1:0] NMAX = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result transaction dropped under stall");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(force_theta) && $stable(force_phi))
		else $error("stalled result changed");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> force_theta == '0 && force_phi == '0 && !saturated)
		else $error("degenerate result not zero");

	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> force_theta == PMAX || force_theta == NMAX ||
			force_phi == PMAX || force_phi == NMAX)
		else $error("saturated flag without a clamped component");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back pressure");
endmodule

bind demons_force_per_vertex dfpv_checker u_dfpv_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.force_theta (force_theta),
	.force_phi   (force_phi),
	.degenerate  (degenerate),
	.saturated   (saturated)
);
`default_nettype wire
